FILE: hdl/swizzle_4kb_tile_address_macros.svh
// Assertion macros for the 4KB tile address generator.
`ifndef SWIZZLE_4KB_TILE_ADDRESS_MACROS_SVH
`define SWIZZLE_4KB_TILE_ADDRESS_MACROS_SVH

`ifndef SYNTH

`define SWZ4K_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swz4k assertion failed");

`define SWZ4K_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swz4k assertion failed");

`else

`define SWZ4K_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SWZ4K_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/swz4k_pkg.sv
// Types, constants and in-tile bit order for the 4KB tile address generator.
package swz4k_pkg;

    localparam int unsigned MAX_DIM_DEF = 16384;
    // wide enough for any saturation limit up to 65536
    localparam int unsigned DIM_W       = 17;
    localparam int unsigned COORD_W     = 14;
    localparam int unsigned PROD_W      = COORD_W + DIM_W;
    localparam int unsigned TILE_W      = PROD_W + 1;
    localparam int unsigned TILED_W     = TILE_W + 12;
    localparam int unsigned LIMIT_W     = 34;
    localparam int unsigned CMP_W       = TILED_W + 1;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 34;

    localparam logic [CFG_IDX_W-1:0] REG_TILING_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_LOG2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILED_LIMIT = 3'd4;

    localparam logic [2:0] ELOG_MAX = 3'd4;

    typedef struct packed {
        logic [13:0] x;
        logic [13:0] y;
    } t_item;

    typedef struct packed {
        logic [32:0] tiled_offset;
        logic [31:0] linear_offset;
        logic        in_range;
    } t_result;

    // decoded config, user keeps stable while items are in flight; unchecked
    typedef struct packed {
        logic               tiling_on;
        logic [2:0]         elog;
        logic [DIM_W-1:0]   w_sat;
        logic [DIM_W-1:0]   tpr;
        logic [LIMIT_W-1:0] limit;
    } t_geom;

    typedef struct packed {
        logic [PROD_W-1:0]  prod_lin;
        logic [PROD_W-1:0]  prod_tile;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] x;
        logic [11:0]        order;
    } t_mid;

    // byte offset within the tile, already scaled by the element size
    function automatic logic [11:0] swz4k_order(input logic [5:0] ix, input logic [5:0] iy,
                                                input logic [2:0] elog);
        logic [11:0] m;
        case (elog)
            3'd0: m = {ix[5], iy[5], ix[4], iy[4], iy[3:0], ix[3:0]};
            3'd1: m = {ix[5], ix[4], iy[4], ix[3], iy[3], ix[2], iy[2],
                       iy[1:0], ix[1:0], 1'b0};
            3'd2: m = {ix[4], iy[4], ix[3], iy[3], ix[2], iy[2], iy[1:0], ix[1:0], 2'b0};
            3'd3: m = {ix[4], ix[3], iy[3], ix[2], iy[2], iy[1:0], ix[1:0], 3'b0};
            default: m = {ix[3], iy[3], ix[2], iy[2], iy[1:0], ix[1:0], 4'b0};
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/swz4k_cfg.sv
// Configuration registers and derived tile geometry.
module swz4k_cfg #(
    parameter int unsigned MAX_DIM = swz4k_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [swz4k_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [swz4k_pkg::CFG_DATA_W-1:0]    i_data,
    output swz4k_pkg::t_geom                    o_geom
);
    import swz4k_pkg::*;

    localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

    logic               r_tiling_on;
    logic [2:0]         r_elog;
    logic [14:0]        r_width;
    logic [14:0]        r_pitch;
    logic [LIMIT_W-1:0] r_limit;

    logic [DIM_W-1:0]   w_sat;
    logic [DIM_W-1:0]   p_sat;
    logic [DIM_W-1:0]   pw;
    logic [DIM_W:0]     pw_round;
    logic [2:0]         elog_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiling_on <= 1'b1;
            r_elog      <= 3'd2;
            r_width     <= 15'd1;
            r_pitch     <= 15'd0;
            r_limit     <= '0;
        end else if (i_wr) begin
            case (i_idx)
                REG_TILING_ON:   r_tiling_on <= i_data[0];
                REG_ELEM_LOG2:   r_elog      <= i_data[2:0];
                REG_WIDTH:       r_width     <= i_data[14:0];
                REG_PITCH:       r_pitch     <= i_data[14:0];
                REG_TILED_LIMIT: r_limit     <= i_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        elog_c = (r_elog > ELOG_MAX) ? ELOG_MAX : r_elog;
        w_sat  = ({2'b0, r_width} > MaxDim) ? MaxDim : {2'b0, r_width};
        p_sat  = ({2'b0, r_pitch} > MaxDim) ? MaxDim : {2'b0, r_pitch};
        pw     = (p_sat != '0) ? p_sat : w_sat;
        // round the pitch up to whole tiles; tile width is 64, 32 or 16 elements
        case (elog_c)
            3'd0, 3'd1: pw_round = {1'b0, pw} + (DIM_W+1)'(63);
            3'd2, 3'd3: pw_round = {1'b0, pw} + (DIM_W+1)'(31);
            default:    pw_round = {1'b0, pw} + (DIM_W+1)'(15);
        endcase
        o_geom.tiling_on = r_tiling_on;
        o_geom.elog      = elog_c;
        o_geom.w_sat     = w_sat;
        o_geom.limit     = r_limit;
        case (elog_c)
            3'd0, 3'd1: o_geom.tpr = DIM_W'(pw_round >> 6);
            3'd2, 3'd3: o_geom.tpr = DIM_W'(pw_round >> 5);
            default:    o_geom.tpr = DIM_W'(pw_round >> 4);
        endcase
    end

endmodule

FILE: hdl/swz4k_mul.sv
// Input register and multiply stage: row products, tile coordinates, in-tile order.
module swz4k_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  swz4k_pkg::t_item    i_item,
    input  swz4k_pkg::t_geom    i_geom,
    output logic                o_valid,
    output swz4k_pkg::t_mid     o_mid
);
    import swz4k_pkg::*;

    logic               r_in_valid;
    t_item              r_item;
    logic               r_mid_valid;
    t_mid               r_mid;
    t_mid               n_mid;
    logic [COORD_W-1:0] ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_valid;
            r_mid_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_item <= i_item;
        end
        if (r_in_valid) begin
            r_mid <= n_mid;
        end
    end

    always_comb begin
        case (i_geom.elog)
            3'd0:    begin n_mid.tx = r_item.x >> 6; ty = r_item.y >> 6; end
            3'd1:    begin n_mid.tx = r_item.x >> 6; ty = r_item.y >> 5; end
            3'd2:    begin n_mid.tx = r_item.x >> 5; ty = r_item.y >> 5; end
            3'd3:    begin n_mid.tx = r_item.x >> 5; ty = r_item.y >> 4; end
            default: begin n_mid.tx = r_item.x >> 4; ty = r_item.y >> 4; end
        endcase
        n_mid.prod_lin  = PROD_W'(r_item.y) * PROD_W'(i_geom.w_sat);
        n_mid.prod_tile = PROD_W'(ty) * PROD_W'(i_geom.tpr);
        n_mid.x         = r_item.x;
        n_mid.order     = swz4k_order(r_item.x[5:0], r_item.y[5:0], i_geom.elog);
    end

    assign o_valid = r_mid_valid;
    assign o_mid   = r_mid;

endmodule

FILE: hdl/swz4k_fin.sv
// Final stage: offset sums, layout select, range compare, result register.
module swz4k_fin (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  swz4k_pkg::t_mid     i_mid,
    input  swz4k_pkg::t_geom    i_geom,
    output logic                o_done,
    output swz4k_pkg::t_result  o_result
);
    import swz4k_pkg::*;

    logic               r_done;
    t_result            r_result;
    t_result            n_result;
    logic [31:0]        lin_sum;
    logic [35:0]        lin_sh;
    logic [TILE_W-1:0]  tile;
    logic [TILED_W-1:0] tiled;
    logic [CMP_W-1:0]   tiled_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    always_comb begin
        lin_sum = 32'(i_mid.prod_lin) + 32'(i_mid.x);
        lin_sh  = {4'b0, lin_sum} << i_geom.elog;
        tile    = TILE_W'(i_mid.prod_tile) + TILE_W'(i_mid.tx);
        if (i_geom.tiling_on) begin
            tiled = {tile, i_mid.order};
        end else begin
            tiled = TILED_W'(lin_sh[31:0]);
        end
        tiled_end = {1'b0, tiled} + (CMP_W'(1) << i_geom.elog);
        n_result.tiled_offset  = tiled[32:0];
        n_result.linear_offset = lin_sh[31:0];
        n_result.in_range      = (tiled_end <= CMP_W'(i_geom.limit));
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: hdl/swizzle_4kb_tile_address.sv
// Top level of the 4KB standard-swizzle tile address generator.
//
//  channel   direction  handshake                       payload
//  item      in         i_start & !o_busy               i_item   (x, y)
//  result    out        o_done, one cycle, no stall     o_result (tiled, linear, in_range)
//  config    in         i_cfg_valid & o_cfg_ready       i_cfg_index, i_cfg_data
//
// One item is accepted every cycle while o_busy is low; its result strobes o_done
// once the transfer has passed the input register, the product register behind the
// two multipliers, and the result register behind the sums and limit compare.
// Synchronous reset restores register defaults; o_busy is high until r_ready sets.
// Results cannot be stalled, so o_busy never rises in operation.
`include "swizzle_4kb_tile_address_macros.svh"

module swizzle_4kb_tile_address #(
    parameter int unsigned MAX_DIM = swz4k_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  swz4k_pkg::t_item                    i_item,
    output logic                                o_done,
    output swz4k_pkg::t_result                  o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swz4k_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swz4k_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import swz4k_pkg::*;

    logic  r_ready;
    logic  accept;
    logic  mid_valid;
    t_mid  mid;
    t_geom geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_busy      = !r_ready;
    assign o_cfg_ready = r_ready;
    assign accept      = i_start && r_ready;

    swz4k_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && r_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_geom  (geom)
    );

    swz4k_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_geom  (geom),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    swz4k_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mid_valid),
        .i_mid    (mid),
        .i_geom   (geom),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // every transfer yields exactly one result strobe, behind the pipeline registers
    `SWZ4K_ASSERT_NEXT(a_accept_to_done, i_clk, i_rst_n, accept, ##2 o_done)
    `SWZ4K_ASSERT_IMPLY(a_done_from_accept, i_clk, i_rst_n, o_done, $past(accept, 3))
    // linear layout: tiled offset mirrors the linear one
    `SWZ4K_ASSERT_IMPLY(a_linear_match, i_clk, i_rst_n, o_done && !geom.tiling_on, (o_result.tiled_offset[31:0] == o_result.linear_offset) && !o_result.tiled_offset[32])

endmodule

FILE: sim/swz4k_addr_checker.sv
// Transfer monitor, offset predictor and result scoreboard for the 4KB tile address generator.
`timescale 1ns / 100ps

module swz4k_addr_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  swz4k_pkg::t_item                    i_item,
    input  logic                                i_done,
    input  swz4k_pkg::t_result                  i_result,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [swz4k_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swz4k_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int unsigned                         o_fail_count,
    output int unsigned                         o_pending
);
    import swz4k_pkg::*;

    localparam logic [63:0] DIM_SAT = 64'(MAX_DIM_DEF);

    // shadow copy of the block's registers
    logic                 tiling_q;
    logic [2:0]           elog_q;
    logic [14:0]          width_q;
    logic [14:0]          pitch_q;
    logic [LIMIT_W-1:0]   limit_q;

    t_result     pending_offsets[$];
    t_result     want;
    int unsigned fail_cnt = 0;

    // in-tile element index: low x, low y, then (y,x) pairs, then leftover x bits
    function automatic logic [11:0] tile_swizzle(input logic [5:0] ix, input logic [5:0] iy,
                                                 input int unsigned bx, input int unsigned by);
        logic [11:0] m;
        int unsigned pos;
        int unsigned lo;
        int unsigned b;
        m = '0;
        pos = 0;
        lo = (bx == 6 && by == 6) ? 4 : 2;
        for (b = 0; b < lo && b < bx; b++) begin
            m[pos] = ix[b];
            pos++;
        end
        for (b = 0; b < lo && b < by; b++) begin
            m[pos] = iy[b];
            pos++;
        end
        for (b = lo; b < by; b++) begin
            m[pos] = iy[b];
            pos++;
            if (b < bx) begin
                m[pos] = ix[b];
                pos++;
            end
        end
        for (b = by; b < bx; b++) begin
            m[pos] = ix[b];
            pos++;
        end
        return m;
    endfunction

    function automatic t_result tile_and_linear_offsets(input t_item it);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] w;
        logic [63:0] p;
        logic [63:0] pw;
        logic [63:0] tpr;
        logic [63:0] tile;
        logic [63:0] lin;
        logic [63:0] tiled;
        logic [63:0] bpe;
        logic [5:0]  ix;
        logic [5:0]  iy;
        int unsigned e;
        int unsigned bx;
        int unsigned by;
        t_result     r;
        x = 64'(it.x);
        y = 64'(it.y);
        e = (elog_q > ELOG_MAX) ? 4 : int'(elog_q);
        bpe = 64'd1 << e;
        w = (64'(width_q) > DIM_SAT) ? DIM_SAT : 64'(width_q);
        p = (64'(pitch_q) > DIM_SAT) ? DIM_SAT : 64'(pitch_q);
        lin = ((y * w + x) << e) & 64'hFFFF_FFFF;
        if (tiling_q) begin
            bx = (13 - e) / 2;
            by = (12 - e) / 2;
            pw = (p != 0) ? p : w;
            tpr = (pw + (64'd1 << bx) - 1) >> bx;
            ix = 6'(x & ((64'd1 << bx) - 1));
            iy = 6'(y & ((64'd1 << by) - 1));
            tile = (y >> by) * tpr + (x >> bx);
            tiled = (tile << 12) + (64'(tile_swizzle(ix, iy, bx, by)) << e);
        end else begin
            tiled = lin;
        end
        r.tiled_offset  = tiled[32:0];
        r.linear_offset = lin[31:0];
        r.in_range      = (tiled + bpe <= 64'(limit_q));
        return r;
    endfunction

    task automatic flag_failure(input string what, input t_result exp_r, input t_result got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s: tiled exp %h got %h, linear exp %h got %h, in_range exp %b got %b",
                     $realtime, what, exp_r.tiled_offset, got.tiled_offset,
                     exp_r.linear_offset, got.linear_offset, exp_r.in_range, got.in_range);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tiling_q = 1'b1;
            elog_q   = 3'd2;
            width_q  = 15'd1;
            pitch_q  = 15'd0;
            limit_q  = '0;
            pending_offsets.delete();
        end else begin
            if (i_done) begin
                if (pending_offsets.size() == 0) begin
                    flag_failure("result with no item outstanding", '0, i_result);
                end else begin
                    want = pending_offsets.pop_front();
                    if (i_result.tiled_offset !== want.tiled_offset ||
                        i_result.linear_offset !== want.linear_offset ||
                        i_result.in_range !== want.in_range) begin
                        flag_failure("offset mismatch", want, i_result);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TILING_ON:   tiling_q = i_cfg_data[0];
                    REG_ELEM_LOG2:   elog_q   = i_cfg_data[2:0];
                    REG_WIDTH:       width_q  = i_cfg_data[14:0];
                    REG_PITCH:       pitch_q  = i_cfg_data[14:0];
                    REG_TILED_LIMIT: limit_q  = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                pending_offsets.push_back(tile_and_linear_offsets(i_item));
            end
        end
        o_pending    <= pending_offsets.size();
        o_fail_count <= fail_cnt;
    end

endmodule

FILE: sim/testbench.sv
// Stimulus, register setup and verdict for the 4KB tile address generator.
`timescale 1ns / 100ps

module testbench;
    import swz4k_pkg::*;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [33:0]          LIMIT_MAX     = 34'h3_FFFF_FFFF;
    localparam logic [13:0]          COORD_MAX     = 14'h3FFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    t_item                 item      = '0;
    logic                  done;
    t_result               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int unsigned           fail_count;
    int unsigned           pending;
    int unsigned           idle_pct  = 19;

    always #6 clk = ~clk;

    swizzle_4kb_tile_address uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (item),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    swz4k_addr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_done       (done),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // sometimes set bits above the register width; the block must ignore them
    function automatic logic [33:0] add_junk(input logic [33:0] v, input int unsigned w);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            return v | 34'(junk << w);
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [33:0] data);
        while ($urandom_range(99) < idle_pct) begin
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic write_geometry(input logic tiling, input logic [2:0] elog,
                                  input logic [14:0] width, input logic [14:0] pitch,
                                  input logic [33:0] limit);
        write_reg(REG_TILING_ON, add_junk(34'(tiling), 1));
        write_reg(REG_ELEM_LOG2, add_junk(34'(elog), 3));
        write_reg(REG_WIDTH, add_junk(34'(width), 15));
        write_reg(REG_PITCH, add_junk(34'(pitch), 15));
        write_reg(REG_TILED_LIMIT, limit);
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED_LO + 3'($urandom_range(2)), 34'({$urandom, $urandom}));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            item  <= t_item'(28'($urandom));
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    // hold off until every accepted item has produced its result
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_corners;
        send_item('{x: 14'd0, y: 14'd0});
        send_item('{x: COORD_MAX, y: COORD_MAX});
        send_item('{x: 14'h2AAA, y: 14'h1555});
        send_item('{x: 14'h1555, y: 14'h2AAA});
        drain();
    endtask

    function automatic logic [14:0] pick_dim(input bit zero_often);
        case ($urandom_range(zero_often ? 7 : 5))
            0: return 15'd1;
            1: return 15'(MAX_DIM_DEF);
            2: return 15'($urandom_range(1, MAX_DIM_DEF));
            3: return 15'($urandom_range(1, 300));
            4: return 15'($urandom_range(MAX_DIM_DEF + 1, 32767));
            default: return 15'd0;
        endcase
    endfunction

    function automatic t_item pick_coord;
        t_item it;
        it = t_item'(28'($urandom));
        case ($urandom_range(3))
            1: begin
                it.x = 14'($urandom_range(127));
                it.y = 14'($urandom_range(127));
            end
            2: begin
                it.x = COORD_MAX - 14'($urandom_range(127));
                it.y = COORD_MAX - 14'($urandom_range(127));
            end
            default: ;
        endcase
        return it;
    endfunction

    initial begin
        logic [33:0] limit;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry first, then the corners of each register
        send_corners();
        write_geometry(1'b1, 3'd0, 15'(MAX_DIM_DEF), 15'd0, LIMIT_MAX);
        send_corners();
        write_geometry(1'b1, 3'd1, 15'd100, 15'(MAX_DIM_DEF), 34'h1_0000_0000);
        write_reg(REG_UNUSED_LO, LIMIT_MAX);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_corners();
        write_geometry(1'b1, 3'd3, 15'd32767, 15'd20000, 34'h0_0123_4567);
        send_corners();
        // element size code past the top clamps; zero width and pitch leave no tile columns
        write_geometry(1'b1, 3'd7, 15'd0, 15'd0, 34'd4096);
        send_corners();
        // linear layout at the largest element size; the largest linear offset here still fits in 32 bits
        write_geometry(1'b0, ELOG_MAX, 15'(MAX_DIM_DEF), 15'd5, LIMIT_MAX);
        send_corners();

        for (int ph = 0; ph < 16; ph++) begin
            idle_pct = (ph >= 6 && ph <= 8) ? 0 : 19;
            case ($urandom_range(3))
                0: limit = '0;
                1: limit = LIMIT_MAX;
                default: limit = 34'({$urandom, $urandom}) >> $urandom_range(33);
            endcase
            write_geometry($urandom_range(3) != 0, 3'($urandom_range(7)),
                           pick_dim(1'b0), pick_dim(1'b1), limit);
            for (int n = 0; n < 80; n++) begin
                send_item(pick_coord());
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: swizzle_4kb_tile_address.f
+incdir+hdl
hdl/swz4k_pkg.sv
hdl/swz4k_cfg.sv
hdl/swz4k_mul.sv
hdl/swz4k_fin.sv
hdl/swizzle_4kb_tile_address.sv
sim/swz4k_addr_checker.sv
sim/testbench.sv
